>>> hw/rtl/ole_pkg.sv
// Shared types and constants for the ordered list engine.
// No dependencies; used by ordered_list_engine_unit.
`default_nettype none

package ole_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   typedef enum logic [2:0] {
      OP_FRONT  = 3'd0,
      OP_BACK   = 3'd1,
      OP_FIND_EQ = 3'd2,
      OP_FIND_GT = 3'd3,
      OP_INSERT = 3'd4,
      OP_TAKE   = 3'd5,
      OP_REMOVE = 3'd6,
      OP_CLEAR  = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_RANGE    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/ole_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; the contents are undefined until written.
`default_nettype none

module ole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/ordered_list_engine_unit.sv
// Ordered list engine: a bounded dense list of signed 32-bit entries.
// Depends on ole_pkg and the ole_ram storage module.
`default_nettype none

// The engine keeps up to ole_pkg::CAPACITY signed entries in a small RAM plus
// a count, and serves one request transaction at a time, returning exactly one
// response transaction per request. All work goes through the single RAM port
// pair, one entry per cycle: a search reads entries from index 0 upward until
// a hit or the end of the list; an add at the front or an insert at index p
// moves every entry from p upward one place; a take or remove at index p moves
// the entries above p down; an add at the back, a clear, and any refused
// request need no walk over the RAM. A new request is taken while the
// previous response still waits in the output register; the engine stalls
// only when a second response is ready before the first has been taken.
// Entries above the count are never read, so the RAM needs no clearing after
// reset.
module ordered_list_engine_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic        [2:0]  req_opcode,
   input  wire logic signed [31:0] req_value,
   input  wire logic        [7:0]  req_position,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic             [2:0]  rsp_status,
   output logic             [7:0]  rsp_found_index,
   output logic signed      [31:0] rsp_taken_value,
   output logic                    rsp_is_empty,
   output logic             [8:0]  rsp_entry_count
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_FILL,
      S_SEARCH,
      S_TAKE,
      S_SHIFT_DN,
      S_DONE
   } state_type;

   state_type                          state_ff, state_in;
   ole_pkg::opcode_type                op_ff, op_in;
   logic signed [ole_pkg::DATA_W-1:0]  value_ff, value_in;
   logic [ole_pkg::IDX_W-1:0]          pos_ff, pos_in;
   logic [ole_pkg::IDX_W-1:0]          cur_ff, cur_in;
   logic [ole_pkg::CNT_W-1:0]          count_ff, count_in;
   ole_pkg::status_type                status_ff, status_in;
   logic [ole_pkg::IDX_W-1:0]          found_ff, found_in;
   logic signed [ole_pkg::DATA_W-1:0]  taken_ff, taken_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [2:0]                         rsp_status_ff, rsp_status_in;
   logic [7:0]                         rsp_found_index_ff, rsp_found_index_in;
   logic signed [31:0]                 rsp_taken_value_ff, rsp_taken_value_in;
   logic                               rsp_is_empty_ff, rsp_is_empty_in;
   logic [8:0]                         rsp_entry_count_ff, rsp_entry_count_in;

   logic                               wr_en;
   logic [ole_pkg::IDX_W-1:0]          wr_addr;
   logic [ole_pkg::DATA_W-1:0]         wr_data;
   logic [ole_pkg::IDX_W-1:0]          rd_addr;
   logic [ole_pkg::DATA_W-1:0]         rd_data;

   ole_pkg::opcode_type                req_op;
   logic                               list_empty;
   logic                               list_full;
   logic                               pos_in_range;
   logic [ole_pkg::IDX_W-1:0]          cnt_idx;
   logic                               hit;

   ole_ram #(
      .WIDTH(ole_pkg::DATA_W),
      .DEPTH(ole_pkg::CAPACITY)
   ) u_entries (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_op       = ole_pkg::opcode_type'(req_opcode);
   assign list_empty   = (count_ff == '0);
   assign list_full    = (count_ff == ole_pkg::FULL_COUNT);
   assign pos_in_range = (9'(req_position) < 9'(count_ff));
   // Only used where the list is not full, so the count fits an index.
   assign cnt_idx      = count_ff[ole_pkg::IDX_W-1:0];

   // The search compare: equality or strictly greater, both signed.
   assign hit = (op_ff == ole_pkg::OP_FIND_EQ) ? ($signed(rd_data) == value_ff)
                                                : ($signed(rd_data) > value_ff);

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      value_in  = value_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      count_in  = count_ff;
      status_in = status_ff;
      found_in  = found_ff;
      taken_in  = taken_ff;

      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_status_in      = rsp_status_ff;
      rsp_found_index_in = rsp_found_index_ff;
      rsp_taken_value_in = rsp_taken_value_ff;
      rsp_is_empty_in    = rsp_is_empty_ff;
      rsp_entry_count_in = rsp_entry_count_ff;

      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = value_ff;
      rd_addr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               value_in  = req_value;
               pos_in    = '0;
               found_in  = '0;
               taken_in  = '0;
               status_in = ole_pkg::ST_OK;
               state_in  = S_DONE;
               unique case (req_op)
                  ole_pkg::OP_FRONT, ole_pkg::OP_BACK: begin
                     if (list_full) begin
                        status_in = ole_pkg::ST_FULL;
                     end else if (req_op == ole_pkg::OP_BACK || list_empty) begin
                        // Appending needs no moves: write at the count directly.
                        wr_en    = 1'b1;
                        wr_addr  = cnt_idx;
                        wr_data  = req_value;
                        count_in = count_ff + 1'b1;
                     end else begin
                        rd_addr  = cnt_idx - 1'b1;
                        cur_in   = cnt_idx;
                        state_in = S_SHIFT_UP;
                     end
                  end
                  ole_pkg::OP_FIND_EQ, ole_pkg::OP_FIND_GT: begin
                     if (list_empty) begin
                        status_in = ole_pkg::ST_EMPTY;
                     end else begin
                        status_in = ole_pkg::ST_NOTFOUND;
                        rd_addr   = '0;
                        cur_in    = '0;
                        state_in  = S_SEARCH;
                     end
                  end
                  ole_pkg::OP_INSERT: begin
                     if (list_empty) begin
                        status_in = ole_pkg::ST_EMPTY;
                     end else if (!pos_in_range) begin
                        status_in = ole_pkg::ST_RANGE;
                     end else if (list_full) begin
                        status_in = ole_pkg::ST_FULL;
                     end else begin
                        pos_in   = req_position[ole_pkg::IDX_W-1:0];
                        rd_addr  = cnt_idx - 1'b1;
                        cur_in   = cnt_idx;
                        state_in = S_SHIFT_UP;
                     end
                  end
                  ole_pkg::OP_TAKE, ole_pkg::OP_REMOVE: begin
                     if (list_empty) begin
                        status_in = ole_pkg::ST_EMPTY;
                     end else if (!pos_in_range) begin
                        status_in = ole_pkg::ST_RANGE;
                     end else begin
                        pos_in   = req_position[ole_pkg::IDX_W-1:0];
                        rd_addr  = req_position[ole_pkg::IDX_W-1:0];
                        state_in = S_TAKE;
                     end
                  end
                  ole_pkg::OP_CLEAR: begin
                     if (list_empty) begin
                        status_in = ole_pkg::ST_EMPTY;
                     end else begin
                        count_in = '0;
                     end
                  end
               endcase
            end
         end

         // Moves entry cur-1 to cur, walking down toward the gap position.
         S_SHIFT_UP: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = rd_data;
            if (cur_ff - 1'b1 == pos_ff) begin
               state_in = S_FILL;
            end else begin
               rd_addr = cur_ff - 2'd2;
               cur_in  = cur_ff - 1'b1;
            end
         end

         S_FILL: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = value_ff;
            count_in = count_ff + 1'b1;
            state_in = S_DONE;
         end

         S_SEARCH: begin
            if (hit) begin
               status_in = ole_pkg::ST_OK;
               found_in  = cur_ff;
               state_in  = S_DONE;
            end else if (ole_pkg::CNT_W'(cur_ff) + 1'b1 == count_ff) begin
               state_in = S_DONE;
            end else begin
               rd_addr = cur_ff + 1'b1;
               cur_in  = cur_ff + 1'b1;
            end
         end

         S_TAKE: begin
            if (op_ff == ole_pkg::OP_TAKE) begin
               taken_in = $signed(rd_data);
            end
            if (ole_pkg::CNT_W'(pos_ff) + 1'b1 == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr  = pos_ff + 1'b1;
               cur_in   = pos_ff;
               state_in = S_SHIFT_DN;
            end
         end

         // Moves entry cur+1 to cur, walking up toward the end of the list.
         S_SHIFT_DN: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = rd_data;
            if (ole_pkg::CNT_W'(cur_ff) + 2'd2 == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr = cur_ff + 2'd2;
               cur_in  = cur_ff + 1'b1;
            end
         end

         // Hands the result to the output register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = status_ff;
               rsp_found_index_in = 8'(found_ff);
               rsp_taken_value_in = taken_ff;
               rsp_is_empty_in    = (count_ff == '0);
               rsp_entry_count_in = 9'(count_ff);
               state_in           = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff              <= op_in;
      value_ff           <= value_in;
      pos_ff             <= pos_in;
      cur_ff             <= cur_in;
      status_ff          <= status_in;
      found_ff           <= found_in;
      taken_ff           <= taken_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_found_index_ff <= rsp_found_index_in;
      rsp_taken_value_ff <= rsp_taken_value_in;
      rsp_is_empty_ff    <= rsp_is_empty_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_index_ff;
   assign rsp_taken_value = rsp_taken_value_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   // The count never grows past the capacity of the storage.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ole_pkg::FULL_COUNT)
      else $error("entry count exceeds capacity");

   // An accepted request always leaves the engine busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("engine ready right after accepting a request");

   // Opening a gap never writes at or below the insert position.
   a_shift_up_above_gap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_UP) |-> (wr_en && wr_addr > pos_ff))
      else $error("gap shift wrote at or below the insert position");

   // A new response appears only when the engine finishes a request.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid && !rsp_ready)) |-> $past(state_ff == S_DONE))
      else $error("response appeared without a finished request");

endmodule

`default_nettype wire
